// File: hw/rtl/bsw_pkg.sv
// ----------------------------------------------------------------------------
// bsw_pkg
// shared types and constants of the 24-bit bmp stream writer
// ----------------------------------------------------------------------------
`default_nettype none

package bsw_pkg;

  // register and field widths
  localparam int CFG_W     = 15;  // width of a dimension register
  localparam int CFG_IDX_W = 1;   // register index width
  localparam int COLOUR_W  = 17;  // unsigned q1.16 colour
  localparam int BYTE_W    = 8;
  localparam int PAD_W     = 2;   // row padding, width mod 4

  localparam int MAX_DIMENSION_DEFAULT = 16384;
  localparam int QUEUE_DEPTH           = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  // first two bytes of every file
  localparam logic [BYTE_W-1:0] BMP_MAGIC_B = 8'h42;
  localparam logic [BYTE_W-1:0] BMP_MAGIC_M = 8'h4D;

  typedef struct packed {
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_of_run;
    logic              end_of_image;
  } file_word_t;

  // one classified pixel, front to back
  typedef struct packed {
    logic              hdr;       // header goes out first
    logic              end_img;   // last pixel of the image
    logic [PAD_W-1:0]  pad;       // zero bytes after this pixel
    logic [CFG_W-1:0]  width;
    logic [CFG_W-1:0]  height;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] red;
  } job_t;

endpackage

`default_nettype wire

// File: hw/rtl/bsw_front.sv
// ----------------------------------------------------------------------------
// bsw_front
// accepts pixels, converts colours and tracks row and column position
// ----------------------------------------------------------------------------
`default_nettype none

module bsw_front #(
  parameter int MAX_DIMENSION = bsw_pkg::MAX_DIMENSION_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [bsw_pkg::CFG_W-1:0]  image_width,
  input  wire logic [bsw_pkg::CFG_W-1:0]  image_height,
  input  wire logic                       pixel_valid,
  input  wire bsw_pkg::pixel_t            pixel,
  input  wire logic                       queue_full,
  output logic                            pixel_stall,
  output logic                            push,
  output bsw_pkg::job_t                   job
);

  localparam int CNT_W = $clog2(MAX_DIMENSION);
  localparam logic [bsw_pkg::CFG_W-1:0] DIM_MAX = bsw_pkg::CFG_W'(MAX_DIMENSION);
  localparam logic [bsw_pkg::CFG_W-1:0] DIM_ONE = bsw_pkg::CFG_W'(1);

  logic [CNT_W-1:0]          column_count;
  logic [CNT_W-1:0]          row_count;
  logic                      header_done;
  logic [bsw_pkg::CFG_W-1:0] w;
  logic [bsw_pkg::CFG_W-1:0] h;
  logic                      col_last;
  logic                      row_last;

  // floor(v * 255 / 65536), saturated
  function automatic logic [bsw_pkg::BYTE_W-1:0] to_byte(
    input logic [bsw_pkg::COLOUR_W-1:0] v
  );
    logic [bsw_pkg::COLOUR_W+7:0] prod;
    logic [8:0]                   q;
    prod = {v, 8'd0} - (bsw_pkg::COLOUR_W+8)'(v);
    q    = prod[bsw_pkg::COLOUR_W+7:16];
    to_byte = (q > 9'd255) ? 8'hFF : q[7:0];
  endfunction

  // zero acts as one, oversize as the maximum
  function automatic logic [bsw_pkg::CFG_W-1:0] clamp_dim(
    input logic [bsw_pkg::CFG_W-1:0] v
  );
    priority if (v == '0) clamp_dim = DIM_ONE;
    else if (v > DIM_MAX) clamp_dim = DIM_MAX;
    else clamp_dim = v;
  endfunction

  always_comb begin
    w        = clamp_dim(image_width);
    h        = clamp_dim(image_height);
    col_last = bsw_pkg::CFG_W'(column_count) >= (w - DIM_ONE);
    row_last = bsw_pkg::CFG_W'(row_count) >= (h - DIM_ONE);

    pixel_stall = queue_full;
    push        = pixel_valid && !queue_full;

    job.hdr     = !header_done;
    job.end_img = col_last && row_last;
    job.pad     = col_last ? w[bsw_pkg::PAD_W-1:0] : '0;
    job.width   = w;
    job.height  = h;
    job.blue    = to_byte(pixel.blue);
    job.green   = to_byte(pixel.green);
    job.red     = to_byte(pixel.red);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      header_done  <= 1'b0;
    end else if (push) begin
      if (col_last) begin
        column_count <= '0;
        if (row_last) begin
          row_count   <= '0;
          header_done <= 1'b0;
        end else begin
          row_count   <= row_count + CNT_W'(1);
          header_done <= 1'b1;
        end
      end else begin
        column_count <= column_count + CNT_W'(1);
        header_done  <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bsw_queue.sv
// ----------------------------------------------------------------------------
// bsw_queue
// short fifo of classified pixels between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module bsw_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire bsw_pkg::job_t  push_job,
  input  wire logic           pop,
  output logic                full,
  output logic                not_empty,
  output bsw_pkg::job_t       head
);

  localparam int DEPTH = bsw_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  bsw_pkg::job_t     mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W:0]    count;

  assign full      = (count == (PTR_W+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (PTR_W+1)'(1);
        2'b01:   count <= count - (PTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bsw_back.sv
// ----------------------------------------------------------------------------
// bsw_back
// byte sequencer: header, pixel bytes and row padding into an output register
// ----------------------------------------------------------------------------
`default_nettype none

module bsw_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               queue_not_empty,
  input  wire bsw_pkg::job_t      head,
  output logic                    pop,
  output logic                    file_valid,
  input  wire logic               file_stall,
  output bsw_pkg::file_word_t     file_word
);

  localparam int POS_W = 6;
  localparam logic [POS_W-1:0] POS_HDR_START = 6'd0;
  localparam logic [POS_W-1:0] POS_BLUE      = 6'd54;
  localparam logic [POS_W-1:0] POS_GREEN     = 6'd55;
  localparam logic [POS_W-1:0] POS_RED       = 6'd56;
  localparam logic [POS_W-1:0] POS_FIELDS    = 6'd2;   // first 32-bit field
  localparam logic [POS_W-1:0] POS_FIELDS_END = 6'd26;
  localparam logic [POS_W-1:0] POS_PLANES    = 6'd26;
  localparam logic [POS_W-1:0] POS_BPP       = 6'd28;

  localparam logic [2:0] FLD_SIZE     = 3'd0;
  localparam logic [2:0] FLD_RESERVED = 3'd1;
  localparam logic [2:0] FLD_OFFSET   = 3'd2;
  localparam logic [2:0] FLD_INFO_LEN = 3'd3;
  localparam logic [2:0] FLD_WIDTH    = 3'd4;
  localparam logic [2:0] FLD_HEIGHT   = 3'd5;

  localparam logic [31:0] HDR_LEN  = 32'd54;
  localparam logic [31:0] INFO_LEN = 32'd40;
  localparam logic [7:0]  PLANES   = 8'd1;
  localparam logic [7:0]  BPP      = 8'd24;

  localparam int PROD_W     = 2 * bsw_pkg::CFG_W;
  localparam int PAD_PROD_W = bsw_pkg::PAD_W + bsw_pkg::CFG_W;

  logic                      active;
  logic [POS_W-1:0]          pos;
  bsw_pkg::job_t             job;
  logic [PROD_W-1:0]         area;
  logic [31:0]               file_size;

  logic                      can_load;
  logic                      emit;
  logic                      is_last;
  logic [bsw_pkg::BYTE_W-1:0] byte_value;

  function automatic logic [7:0] hdr_byte(
    input logic [POS_W-1:0]          p,
    input logic [31:0]               size,
    input logic [bsw_pkg::CFG_W-1:0] w,
    input logic [bsw_pkg::CFG_W-1:0] h
  );
    logic [POS_W-1:0] off;
    logic [31:0]      field;
    off   = p - POS_FIELDS;
    field = '0;
    priority if (p == POS_HDR_START) begin
      hdr_byte = bsw_pkg::BMP_MAGIC_B;
    end else if (p == POS_HDR_START + 6'd1) begin
      hdr_byte = bsw_pkg::BMP_MAGIC_M;
    end else if (p < POS_FIELDS_END) begin
      unique case (off[4:2])
        FLD_SIZE:     field = size;
        FLD_RESERVED: field = '0;
        FLD_OFFSET:   field = HDR_LEN;
        FLD_INFO_LEN: field = INFO_LEN;
        FLD_WIDTH:    field = 32'(w);
        FLD_HEIGHT:   field = 32'(h);
        default:      field = '0;
      endcase
      hdr_byte = field[8*off[1:0] +: 8];
    end else if (p == POS_PLANES) begin
      hdr_byte = PLANES;
    end else if (p == POS_BPP) begin
      hdr_byte = BPP;
    end else begin
      hdr_byte = '0;
    end
  endfunction

  always_comb begin
    can_load = !file_valid || !file_stall;
    emit     = active && can_load;
    is_last  = (pos == POS_RED + POS_W'(job.pad));
    pop      = queue_not_empty && (!active || (emit && is_last));

    priority if (pos < POS_BLUE) byte_value = hdr_byte(pos, file_size, job.width, job.height);
    else if (pos == POS_BLUE)    byte_value = job.blue;
    else if (pos == POS_GREEN)   byte_value = job.green;
    else if (pos == POS_RED)     byte_value = job.red;
    else                         byte_value = '0;
  end

  // file size from the current job, computed through the area register and then the file_size register
  // every row carries width mod 4 padding bytes
  always_ff @(posedge clk) begin
    area      <= job.width * job.height;
    file_size <= HDR_LEN + 32'(area) + {area[PROD_W-2:0], 1'b0}
               + 32'(PAD_PROD_W'(job.width[bsw_pkg::PAD_W-1:0])
                     * PAD_PROD_W'(job.height));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      file_valid <= 1'b0;
    end else begin
      if (can_load) begin
        file_valid <= emit;
      end
      if (pop) begin
        active <= 1'b1;
      end else if (emit && is_last) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      file_word.data_byte    <= byte_value;
      file_word.last_of_run  <= is_last;
      file_word.end_of_image <= is_last && job.end_img;
    end
    if (pop) begin
      job <= head;
      pos <= head.hdr ? POS_HDR_START : POS_BLUE;
    end else if (emit) begin
      pos <= pos + POS_W'(1);
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bmp24_stream_writer.sv
// ----------------------------------------------------------------------------
// bmp24_stream_writer
// streams an uncompressed 24-bit bmp file from a raster of q1.16 pixels
// ----------------------------------------------------------------------------
// pixels come in bottom row first, one word each, and leave as a byte stream:
// the 54-byte header ahead of the first pixel of an image, then blue, green and
// red bytes per pixel and width mod 4 zero bytes after each row's last pixel.
// the output is one byte per cycle while it is not stalled and pixels are
// queued; the byte sequencer in the back end sets that rate. a four-word queue
// sits between the pixel front end and the sequencer, so pixels keep being
// taken until it fills while bytes wait on a stalled output. width and height
// are to be written through the register port between images, which the block
// itself does not enforce; zero acts as one and values above MAX_DIMENSION act
// as MAX_DIMENSION
// ----------------------------------------------------------------------------
`default_nettype none

module bmp24_stream_writer #(
  parameter int MAX_DIMENSION = bsw_pkg::MAX_DIMENSION_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // register port
  input  wire logic                          cfg_write,
  input  wire logic [bsw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bsw_pkg::CFG_W-1:0]     cfg_data,
  // pixel words in
  input  wire logic                          pixel_valid,
  output logic                               pixel_stall,
  input  wire bsw_pkg::pixel_t               pixel,
  // file bytes out
  output logic                               file_valid,
  input  wire logic                          file_stall,
  output bsw_pkg::file_word_t                file_word
);

  // dimension registers
  logic [bsw_pkg::CFG_W-1:0] image_width;
  logic [bsw_pkg::CFG_W-1:0] image_height;

  // front to queue
  logic          push;
  logic          queue_full;
  bsw_pkg::job_t push_job;

  // queue to back
  logic          pop;
  logic          queue_not_empty;
  bsw_pkg::job_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bsw_pkg::CFG_W'(1);
      image_height <= bsw_pkg::CFG_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        bsw_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        bsw_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // pixel front end: colour conversion and raster position
  bsw_front #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .image_width  (image_width),
    .image_height (image_height),
    .pixel_valid  (pixel_valid),
    .pixel        (pixel),
    .queue_full   (queue_full),
    .pixel_stall  (pixel_stall),
    .push         (push),
    .job          (push_job)
  );

  // decoupling queue
  bsw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .head      (head)
  );

  // byte sequencer and output register
  bsw_back u_back (
    .clk             (clk),
    .rst             (rst),
    .queue_not_empty (queue_not_empty),
    .head            (head),
    .pop             (pop),
    .file_valid      (file_valid),
    .file_stall      (file_stall),
    .file_word       (file_word)
  );

endmodule

`default_nettype wire

// File: hw/rtl/bsw_checker.sv
// ----------------------------------------------------------------------------
// bsw_checker
// port-level checks of the bmp stream writer
// ----------------------------------------------------------------------------
`default_nettype none

module bsw_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                file_valid,
  input wire logic                file_stall,
  input wire bsw_pkg::file_word_t file_word
);

  logic file_start;  // next byte opens a new file

  always_ff @(posedge clk) begin
    if (rst) begin
      file_start <= 1'b1;
    end else if (file_valid && !file_stall) begin
      file_start <= file_word.end_of_image;
    end
  end

  a_idle_after_reset : assert property (@(posedge clk)
    rst |=> !file_valid)
    else $error("output word valid straight after reset");

  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    file_valid && file_stall |=> file_valid && $stable(file_word))
    else $error("stalled output word changed");

  a_end_is_last : assert property (@(posedge clk) disable iff (rst)
    file_valid && file_word.end_of_image |-> file_word.last_of_run)
    else $error("end of image on a word that does not close its pixel");

  a_file_opens_with_magic : assert property (@(posedge clk) disable iff (rst)
    file_valid && file_start |->
      file_word.data_byte == bsw_pkg::BMP_MAGIC_B && !file_word.last_of_run)
    else $error("file does not open with the bmp signature");

endmodule

bind bmp24_stream_writer bsw_checker u_bsw_checker (
  .clk        (clk),
  .rst        (rst),
  .file_valid (file_valid),
  .file_stall (file_stall),
  .file_word  (file_word)
);

`default_nettype wire

// File: verif/bmp24_stream_writer_tb.sv
// ----------------------------------------------------------------------------
// bmp24_stream_writer_tb
// self-checking bench for the 24-bit bmp stream writer
// ----------------------------------------------------------------------------
// pixel words go in through the valid/stall port and every file byte coming
// out is compared with a predicted byte stream: the 54-byte header on the
// first pixel of each image, blue/green/red bytes per pixel and the zero
// padding after each row. a short directed pass covers the colour extremes,
// zero and oversize dimensions and dimension changes part way through an
// image; then random images, mostly small, with random colours, with gaps on
// both sides and one long output hold that fills the block
// ----------------------------------------------------------------------------
`default_nettype none

module bmp24_stream_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no word moving
  localparam int SETTLE_CYCLES  = 12;    // quiet time after the last byte
  localparam int LONG_HOLD      = 240;   // output hold while pixels keep coming
  localparam int RANDOM_PIXELS  = 130;

  // fixed header fields
  localparam int HEADER_BYTES   = 54;
  localparam int INFO_BYTES     = 40;
  localparam int BITS_PER_PIXEL = 24;
  localparam int RESERVED_BYTES = 24;

  // --------------------------------------------------------------------------
  // predictor and byte checker
  // --------------------------------------------------------------------------
  class file_scoreboard;
    logic [bsw_pkg::CFG_W-1:0] width_reg;
    logic [bsw_pkg::CFG_W-1:0] height_reg;
    bit [13:0]                 column;
    bit [13:0]                 row;
    bit                        header_sent;
    logic [7:0]                run_bytes[$];     // bytes caused by the pixel in hand
    bsw_pkg::file_word_t       expected_words[$];
    int                        errors;
    int                        words_checked;
    int                        pixels_taken;
    int                        images_closed;
    int                        reg_writes;

    function new();
      width_reg   = bsw_pkg::CFG_W'(1);
      height_reg  = bsw_pkg::CFG_W'(1);
      column      = '0;
      row         = '0;
      header_sent = 1'b0;
    endfunction

    // zero acts as one, oversize as the maximum
    function int unsigned effective_dim(logic [bsw_pkg::CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > bsw_pkg::MAX_DIMENSION_DEFAULT) return bsw_pkg::MAX_DIMENSION_DEFAULT;
      return 32'(v);
    endfunction

    // floor(v * 255 / 65536), saturated
    function logic [7:0] colour_byte(logic [bsw_pkg::COLOUR_W-1:0] v);
      logic [bsw_pkg::COLOUR_W+7:0] scaled;
      scaled = {8'd0, v} * 25'd255;
      scaled = scaled >> 16;
      return (scaled > 255) ? 8'hFF : scaled[7:0];
    endfunction

    function void add_le32(logic [31:0] v);
      for (int i = 0; i < 4; i++) run_bytes.push_back(v[8*i +: 8]);
    endfunction

    function void note_register(logic [bsw_pkg::CFG_IDX_W-1:0] idx,
                                logic [bsw_pkg::CFG_W-1:0] val);
      case (idx)
        bsw_pkg::REG_IMAGE_WIDTH:  width_reg = val;
        bsw_pkg::REG_IMAGE_HEIGHT: height_reg = val;
        default: ;
      endcase
      reg_writes++;
    endfunction

    function void note_pixel(bsw_pkg::pixel_t px);
      int unsigned         w;
      int unsigned         h;
      int unsigned         pad;
      logic [63:0]         file_size;
      bit                  closes;
      bsw_pkg::file_word_t wd;
      w      = effective_dim(width_reg);
      h      = effective_dim(height_reg);
      pad    = w % 4;
      closes = 1'b0;
      run_bytes.delete();
      if (!header_sent) begin
        file_size = 64'(HEADER_BYTES) + 64'(w) * 64'(h) * 64'd3 + 64'(pad) * 64'(h);
        run_bytes.push_back(bsw_pkg::BMP_MAGIC_B);
        run_bytes.push_back(bsw_pkg::BMP_MAGIC_M);
        add_le32(file_size[31:0]);
        add_le32(32'd0);
        add_le32(HEADER_BYTES);
        add_le32(INFO_BYTES);
        add_le32(w);
        add_le32(h);
        run_bytes.push_back(8'd1);
        run_bytes.push_back(8'd0);
        run_bytes.push_back(8'(BITS_PER_PIXEL));
        run_bytes.push_back(8'd0);
        repeat (RESERVED_BYTES) run_bytes.push_back(8'd0);
        header_sent = 1'b1;
      end
      run_bytes.push_back(colour_byte(px.blue));
      run_bytes.push_back(colour_byte(px.green));
      run_bytes.push_back(colour_byte(px.red));
      // a counter at or past the last index closes the row or image
      if (column >= w - 1) begin
        repeat (pad) run_bytes.push_back(8'd0);
        column = '0;
        if (row >= h - 1) begin
          row         = '0;
          header_sent = 1'b0;
          closes      = 1'b1;
          images_closed++;
        end else begin
          row = row + 1'b1;
        end
      end else begin
        column = column + 1'b1;
      end
      foreach (run_bytes[i]) begin
        wd.data_byte    = run_bytes[i];
        wd.last_of_run  = (i == run_bytes.size() - 1);
        wd.end_of_image = wd.last_of_run && closes;
        expected_words.push_back(wd);
      end
      pixels_taken++;
    endfunction

    task report_fault(string msg);
      errors++;
      if (errors <= 100) $display("[%0t] ERROR %s", $time, msg);
    endtask

    task check_word(bsw_pkg::file_word_t got);
      bsw_pkg::file_word_t want;
      if (expected_words.size() == 0) begin
        report_fault($sformatf("unexpected word data %02h", got.data_byte));
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (got.data_byte !== want.data_byte)
          report_fault($sformatf("byte %0d data_byte %02h, wanted %02h",
                                 words_checked, got.data_byte, want.data_byte));
        if (got.last_of_run !== want.last_of_run)
          report_fault($sformatf("byte %0d last_of_run %b, wanted %b",
                                 words_checked, got.last_of_run, want.last_of_run));
        if (got.end_of_image !== want.end_of_image)
          report_fault($sformatf("byte %0d end_of_image %b, wanted %b",
                                 words_checked, got.end_of_image, want.end_of_image));
      end
    endtask

    function bit at_image_start();
      return !header_sent;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block
  // --------------------------------------------------------------------------
  logic                          clk         = 1'b0;
  logic                          rst         = 1'b1;
  logic                          cfg_write   = 1'b0;
  logic [bsw_pkg::CFG_IDX_W-1:0] cfg_index   = bsw_pkg::REG_IMAGE_WIDTH;
  logic [bsw_pkg::CFG_W-1:0]     cfg_data    = '0;
  logic                          pixel_valid = 1'b0;
  logic                          pixel_stall;
  bsw_pkg::pixel_t               pixel       = '0;
  logic                          file_valid;
  logic                          file_stall  = 1'b0;
  bsw_pkg::file_word_t           file_word;

  file_scoreboard sb;
  bit             hold_request = 1'b0;  // asks the receiver for one long hold
  int             idle_cycles  = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  bmp24_stream_writer DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .file_valid  (file_valid),
    .file_stall  (file_stall),
    .file_word   (file_word)
  );

  // --------------------------------------------------------------------------
  // monitor: accepted pixels feed the predictor, accepted bytes are checked,
  // all in one process so nothing hangs on event order within a step
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (pixel_valid && pixel_stall === 1'b0) sb.note_pixel(pixel);
      if (file_valid === 1'b1 && !file_stall) sb.check_word(file_word);
      if ((pixel_valid && pixel_stall === 1'b0) || (file_valid === 1'b1 && !file_stall)
          || cfg_write) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      // watchdog: nothing moved for too long
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("bmp24_stream_writer: mismatch");
        $finish;
      end
    end
  end

  // mostly back to back, sometimes a short gap, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // --------------------------------------------------------------------------
  // receiver: random stall bursts, free-running stretches and the long hold
  // --------------------------------------------------------------------------
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request) begin
        // hold long enough for the internal queue to fill and stall the input
        file_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          file_stall <= 1'b1;
          repeat (gap) @(negedge clk);
        end
        file_stall <= 1'b0;
        if ($urandom_range(0, 9) == 0) repeat (60) @(negedge clk);
        else repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // sender side tasks, all entered and left on a falling edge
  // --------------------------------------------------------------------------
  function automatic bsw_pkg::pixel_t make_pixel(logic [bsw_pkg::COLOUR_W-1:0] r,
                                                 logic [bsw_pkg::COLOUR_W-1:0] g,
                                                 logic [bsw_pkg::COLOUR_W-1:0] b);
    bsw_pkg::pixel_t p;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    return p;
  endfunction

  // mostly in range, with the edges and over-range values mixed in
  function automatic logic [bsw_pkg::COLOUR_W-1:0] random_colour();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 17'd65535;
      2:       return 17'd65536;
      3:       return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic bsw_pkg::pixel_t random_pixel();
    return make_pixel(random_colour(), random_colour(), random_colour());
  endfunction

  task automatic send_pixel(input bsw_pkg::pixel_t p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= p;
    do @(posedge clk); while (pixel_stall !== 1'b0);
    @(negedge clk);
  endtask

  // keep sending until the image in progress has closed
  task automatic finish_image();
    do send_pixel(random_pixel()); while (!sb.at_image_start());
  endtask

  // drop valid and let every expected byte come out before touching registers
  task automatic wait_drained();
    pixel_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [bsw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bsw_pkg::CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    sb.note_register(idx, val);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_size(input logic [bsw_pkg::CFG_W-1:0] w,
                          input logic [bsw_pkg::CFG_W-1:0] h);
    write_reg(bsw_pkg::REG_IMAGE_WIDTH, w);
    write_reg(bsw_pkg::REG_IMAGE_HEIGHT, h);
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [bsw_pkg::COLOUR_W-1:0] corner[6];
    int                           first_random;
    int                           phase;
    logic [bsw_pkg::CFG_W-1:0]    w;
    logic [bsw_pkg::CFG_W-1:0]    h;

    corner = '{17'd0, 17'd1, 17'd255, 17'd65535, 17'd65536, 17'd131071};
    sb     = new();
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // one pixel at the reset size of 1 x 1, black
    send_pixel(make_pixel('0, '0, '0));
    wait_drained();

    // zero dimensions act as one; full scale and over-range colours
    set_size('0, '0);
    send_pixel(make_pixel(17'd65536, 17'd65535, 17'd131071));
    wait_drained();

    // 3 x 2 with three padding bytes per row, colour corners rotated
    set_size(15'd3, 15'd2);
    for (int i = 0; i < 6; i++)
      send_pixel(make_pixel(corner[i], corner[5 - i], corner[(i + 2) % 6]));
    wait_drained();

    // largest header: oversize width clamps, height at the maximum; then shrink
    // to 1 x 1 part way so the counters past the end close the image
    set_size(15'h7FFF, 15'(bsw_pkg::MAX_DIMENSION_DEFAULT));
    send_pixel(random_pixel());
    send_pixel(random_pixel());
    wait_drained();
    set_size(15'd1, 15'd1);
    send_pixel(random_pixel());
    wait_drained();

    // narrower rows part way through a 5 x 3 image
    set_size(15'd5, 15'd3);
    repeat (7) send_pixel(random_pixel());
    wait_drained();
    write_reg(bsw_pkg::REG_IMAGE_WIDTH, 15'd2);
    finish_image();
    wait_drained();

    // random images, mostly small; a few huge ones cut short by a resize
    first_random = sb.pixels_taken;
    phase        = 0;
    while (sb.pixels_taken - first_random < RANDOM_PIXELS) begin
      if (phase == 2) begin
        // output held while a 9 x 3 image keeps coming in
        set_size(15'd9, 15'd3);
        hold_request = 1'b1;
        finish_image();
      end else if ($urandom_range(0, 7) == 0) begin
        w = 15'($urandom_range(0, 32767));
        h = 15'($urandom_range(0, 32767));
        set_size(w, h);
        repeat ($urandom_range(1, 4)) send_pixel(random_pixel());
        wait_drained();
        if (!sb.at_image_start()) begin
          set_size(15'($urandom_range(1, 6)), 15'($urandom_range(1, 3)));
          finish_image();
        end
      end else begin
        set_size(15'($urandom_range(0, 9)), 15'($urandom_range(0, 4)));
        finish_image();
      end
      wait_drained();
      phase++;
    end

    // anything still waiting is a missing byte
    while (sb.pending() != 0) begin
      sb.report_fault("expected byte never arrived");
      void'(sb.expected_words.pop_front());
    end

    $display("run covered %0d pixels, %0d file bytes and %0d finished images",
             sb.pixels_taken, sb.words_checked, sb.images_closed);
    $display("%0d register writes, incl. zero, oversize and mid-image sizes; %0d errors",
             sb.reg_writes, sb.errors);
    if (sb.errors == 0) begin
      $display("bmp24_stream_writer: match");
    end else begin
      $display("bmp24_stream_writer: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
